FILE: sv/lus_pkg.sv
// shared widths, register indexes and helpers for the largest uniform square block
`default_nettype none

package lus_pkg;

    localparam int VALUE_W    = 32;
    localparam int SIDE_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic        [SIDE_W-1:0]  t_side;
    typedef logic        [CFG_IDX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_NUM_ROWS = 2'd0;
    localparam t_cfg_index CFG_NUM_COLS = 2'd1;

    localparam t_side SIDE_ONE = t_side'(1);

    function automatic t_side min3(input t_side a, input t_side b, input t_side c);
        t_side m;
        m = a;
        if (b < m) begin
            m = b;
        end
        if (c < m) begin
            m = c;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: sv/lus_cell_if.sv
// stream interface carrying one matrix cell per item
`default_nettype none

interface lus_cell_if;
    logic            valid;
    logic            ready;
    lus_pkg::t_value cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

`default_nettype wire

FILE: sv/lus_side_if.sv
// stream interface carrying one largest-side result per item
`default_nettype none

interface lus_side_if;
    logic           valid;
    logic           ready;
    lus_pkg::t_side largest_side;

    modport source (output valid, output largest_side, input ready);
    modport sink   (input valid, input largest_side, output ready);
endinterface

`default_nettype wire

FILE: sv/largest_uniform_square_core.sv
// top level: streaming search for the largest square of equal cells
// Cells arrive in raster order, one item per cycle. Each accepted cell reads its column of
// the line store in the accept cycle and is resolved in the cycle after against its upper,
// left and upper-left neighbours, so the sustained rate is one cell per clock, set by the
// single read and single write port of the line store. The result of a matrix is registered
// once its final cell is resolved. Results wait in a two-entry output buffer,
// so back-to-back final cells, a stream of 1x1 matrices for instance, still run at one cell
// per clock while the result side keeps up; a final cell is held off only when a stalled
// result side has filled that buffer. There is no clearing pass: line store data is used
// only in rows the matrix has already written. A row or column count write restarts it.
`default_nettype none

module largest_uniform_square_core #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lus_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lus_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lus_cell_if.sink                            i_cell,
    lus_side_if.source                          o_side
);

    localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int VW  = lus_pkg::VALUE_W;
    localparam int SW  = lus_pkg::SIDE_W;
    localparam int MW  = VW + SW;

    logic [lus_pkg::CFG_DATA_W-1:0] r_num_rows;
    logic [lus_pkg::CFG_DATA_W-1:0] r_num_cols;
    logic [CCW-1:0]                 cols_eff;
    logic [RCW-1:0]                 rows_eff;

    logic [CCW-1:0] r_col_count, n_col_count;
    logic [RCW-1:0] r_row_count, n_row_count;
    logic           col_last, row_last, cur_last, in_accept;

    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic                   r_s1_first_row;
    logic                   r_s1_first_col;
    logic [AW-1:0]          r_s1_col;
    lus_pkg::t_value        r_s1_value;

    lus_pkg::t_value r_left_value;
    lus_pkg::t_side  r_left_side;
    lus_pkg::t_value r_diag_value;
    lus_pkg::t_side  r_diag_side;
    lus_pkg::t_side  r_best_side, n_best_side;

    logic            r_out_valid, n_out_valid;
    lus_pkg::t_side  r_out_side, n_out_side;
    logic            r_skid_valid, n_skid_valid;
    lus_pkg::t_side  r_skid_side, n_skid_side;
    logic            out_push, out_pop;
    logic [1:0]      out_load;

    logic [MW-1:0]   ram_rdata;
    logic [MW-1:0]   ram_wdata;
    lus_pkg::t_value up_value;
    lus_pkg::t_side  up_side;
    lus_pkg::t_side  s1_side;

    // clamp the size registers to the usable range
    always_comb begin
        if (r_num_cols == '0) begin
            cols_eff = CCW'(1);
        end else if (32'(r_num_cols) > 32'(MAX_COLS)) begin
            cols_eff = CCW'(MAX_COLS);
        end else begin
            cols_eff = CCW'(r_num_cols);
        end
        if (r_num_rows == '0) begin
            rows_eff = RCW'(1);
        end else if (32'(r_num_rows) > 32'(MAX_ROWS)) begin
            rows_eff = RCW'(MAX_ROWS);
        end else begin
            rows_eff = RCW'(r_num_rows);
        end
    end

    assign col_last = (r_col_count + CCW'(1)) == cols_eff;
    assign row_last = (r_row_count + RCW'(1)) == rows_eff;
    assign cur_last = col_last && row_last;

    // results still to leave once this edge has passed
    assign out_push = r_s1_valid && r_s1_last;
    assign out_pop  = r_out_valid && o_side.ready;
    assign out_load = 2'(out_push) + 2'(r_out_valid) + 2'(r_skid_valid) - 2'(out_pop);

    // the final cell waits until the output buffer is sure to have room
    assign i_cell.ready = !cur_last || (out_load < 2'd2);
    assign in_accept    = i_cell.valid && i_cell.ready;

    always_comb begin
        n_col_count = r_col_count;
        n_row_count = r_row_count;
        if (in_accept) begin
            if (col_last) begin
                n_col_count = '0;
                if (row_last) begin
                    n_row_count = '0;
                end else begin
                    n_row_count = r_row_count + RCW'(1);
                end
            end else begin
                n_col_count = r_col_count + CCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows  <= lus_pkg::CFG_DATA_W'(1);
            r_num_cols  <= lus_pkg::CFG_DATA_W'(1);
            r_col_count <= '0;
            r_row_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lus_pkg::CFG_NUM_ROWS: begin
                    r_num_rows  <= i_cfg_data;
                    r_col_count <= '0;
                    r_row_count <= '0;
                end
                lus_pkg::CFG_NUM_COLS: begin
                    r_num_cols  <= i_cfg_data;
                    r_col_count <= '0;
                    r_row_count <= '0;
                end
                default: begin
                    r_col_count <= n_col_count;
                    r_row_count <= n_row_count;
                end
            endcase
        end else begin
            r_col_count <= n_col_count;
            r_row_count <= n_row_count;
        end
    end

    // line store: previous row values and sides, one column per entry
    assign ram_wdata = {r_s1_value, s1_side};
    assign up_value  = ram_rdata[MW-1:SW];
    assign up_side   = ram_rdata[SW-1:0];

    lus_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_COLS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (ram_wdata),
        .i_raddr (r_col_count[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_last      <= cur_last;
            r_s1_first_row <= (r_row_count == '0);
            r_s1_first_col <= (r_col_count == '0);
            r_s1_col       <= r_col_count[AW-1:0];
            r_s1_value     <= i_cell.cell_value;
        end
    end

    // side of the square ending at this cell
    always_comb begin
        s1_side = lus_pkg::SIDE_ONE;
        if (!r_s1_first_row && !r_s1_first_col && (up_value == r_s1_value) &&
            (r_left_value == r_s1_value) && (r_diag_value == r_s1_value)) begin
            s1_side = lus_pkg::min3(up_side, r_left_side, r_diag_side) + lus_pkg::SIDE_ONE;
        end
        n_best_side = (s1_side > r_best_side) ? s1_side : r_best_side;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_left_value <= r_s1_value;
            r_left_side  <= s1_side;
            r_diag_value <= up_value;
            r_diag_side  <= up_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_side <= lus_pkg::SIDE_ONE;
        end else if (i_cfg_we && ((i_cfg_index == lus_pkg::CFG_NUM_ROWS) ||
                                  (i_cfg_index == lus_pkg::CFG_NUM_COLS))) begin
            r_best_side <= lus_pkg::SIDE_ONE;
        end else if (r_s1_valid) begin
            r_best_side <= r_s1_last ? lus_pkg::SIDE_ONE : n_best_side;
        end
    end

    // two-entry result buffer: head register and skid register
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_side   = r_out_side;
        n_skid_valid = r_skid_valid;
        n_skid_side  = r_skid_side;
        if (out_pop) begin
            n_out_valid  = r_skid_valid;
            n_out_side   = r_skid_side;
            n_skid_valid = 1'b0;
        end
        if (out_push) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out_side  = n_best_side;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_side  = n_best_side;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_side  <= n_out_side;
        r_skid_side <= n_skid_side;
    end

    assign o_side.valid        = r_out_valid;
    assign o_side.largest_side = r_out_side;

    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_push && r_skid_valid) |-> out_pop)
        else $error("final item would overwrite a pending result");

    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result ahead of the head");

    a_counters_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col_count < cols_eff) && (r_row_count < rows_eff))
        else $error("position counters beyond matrix size");

    a_result_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_side != '0))
        else $error("result side is zero");

    a_best_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1_last && !i_cfg_we) |=> (r_best_side >= $past(s1_side)))
        else $error("running best below a resolved side");

endmodule

`default_nettype wire

FILE: sv/lus_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module lus_ram #(
    parameter int WIDTH = 43,
    parameter int DEPTH = 1024
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
